@@ design/sxid_pkg.sv @@
// Shared types, opcode constants and the opcode format table for the SIC/XE decoder.
// No dependencies; imported by sicxe_instruction_decoder_core.
`default_nettype none

package sxid_pkg;

    typedef enum logic [2:0] {
        KIND_FMT1  = 3'd0,
        KIND_FMT2  = 3'd1,
        KIND_FMT3  = 3'd2,
        KIND_FMT4  = 3'd3,
        KIND_WORD  = 3'd4,
        KIND_BYTE  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        AM_SIMPLE    = 2'd0,
        AM_IMMEDIATE = 2'd1,
        AM_INDIRECT  = 2'd2
    } t_amode;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_1    = 2'd1,
        FMT_2    = 2'd2,
        FMT_34   = 2'd3
    } t_fmt;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  size;
        logic [7:0]  opcode;
        t_amode      addr_mode;
        logic        indexed;
        logic [3:0]  reg_one;
        logic [3:0]  reg_two;
        logic [19:0] target;
        logic        relocatable;
        logic        printable;
        logic        sets_base;
    } t_dec;

    localparam logic [7:0] OPC_MASK = 8'hFC;
    localparam logic [7:0] OP_RSUB  = 8'h4C;
    localparam logic [7:0] OP_LDB   = 8'h68;
    localparam logic [7:0] OP_CLEAR = 8'hB4;
    localparam logic [7:0] OP_TIXR  = 8'hB8;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    function automatic t_fmt opcode_format(input logic [5:0] idx);
        t_fmt f;
        case (idx) inside
            [6'd0:6'd7], [6'd9:6'd16], [6'd18:6'd22], [6'd25:6'd27],
            6'd29, 6'd34, 6'd54, 6'd55, 6'd56: f = FMT_34;
            6'd40, 6'd45, 6'd46:                f = FMT_2;
            6'd48, 6'd49, [6'd60:6'd62]:        f = FMT_1;
            default:                            f = FMT_NONE;
        endcase
        return f;
    endfunction

    function automatic logic is_printable(input logic [7:0] v);
        return (v >= PRINT_LO) && (v <= PRINT_HI);
    endfunction

endpackage

`default_nettype wire

@@ design/sicxe_instruction_decoder_core.sv @@
// SIC/XE instruction decoder: input register, single-pass decode, result register.
// Depends on sxid_pkg for the opcode table, result struct and constants.
// Each accepted input is held in the input register, decoded, and loaded into the result register.
// One item per cycle while the output is not stalled; the decode between the two registers is one pass.
// An LDB updates the base register as its result is loaded, in time for the next item.
// Reset (synchronous, active low) clears both valid flags and the base register.
`default_nettype none

module sicxe_instruction_decoder_core
    import sxid_pkg::*;
#(
    parameter int ADDR_WIDTH = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // location[19:0], byte_first[27:20], byte_second[35:28], byte_third[43:36],
    // byte_fourth[51:44], bytes_left[54:52], zero fill [55]
    input  wire logic [55:0] i_s_tdata,
    // modified[0]
    input  wire logic [0:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // size[2:0], opcode[10:3], addr_mode[12:11], indexed[13], reg_one[17:14],
    // reg_two[21:18], target[41:22], relocatable[42], printable[43], sets_base[44],
    // zero fill [47:45]
    output logic [47:0]      o_m_tdata,
    // kind[2:0]
    output logic [2:0]       o_m_tuser
);

    localparam logic [19:0] TGT_MASK = (ADDR_WIDTH >= 20) ? 20'hFFFFF
                                                          : 20'((1 << ADDR_WIDTH) - 1);

    logic        r_in_valid;
    logic [54:0] r_in_data;
    logic        r_in_mod;
    logic        r_out_valid;
    t_dec        r_out;
    logic [19:0] r_base;
    logic        r_base_valid;

    logic        w_adv;
    logic        w_load_base;
    logic [19:0] w_loc;
    logic [7:0]  w_b1, w_b2, w_b3, w_b4;
    logic [2:0]  w_left_raw, w_left;
    logic [7:0]  w_op;
    t_fmt        w_fmt;
    logic        w_n, w_i, w_x, w_b, w_p, w_e;
    logic [11:0] w_disp;
    logic [19:0] w_tgt;
    t_dec        w_byte, w_word, w_dec;

    assign w_adv       = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || w_adv;
    assign w_load_base = w_adv && r_in_valid && w_dec.sets_base;

    assign w_loc      = r_in_data[19:0];
    assign w_b1       = r_in_data[27:20];
    assign w_b2       = r_in_data[35:28];
    assign w_b3       = r_in_data[43:36];
    assign w_b4       = r_in_data[51:44];
    assign w_left_raw = r_in_data[54:52];

    assign w_op   = w_b1 & OPC_MASK;
    assign w_fmt  = opcode_format(w_op[7:2]);
    assign w_n    = w_b1[1];
    assign w_i    = w_b1[0];
    assign w_x    = w_b2[7];
    assign w_b    = w_b2[6];
    assign w_p    = w_b2[5];
    assign w_e    = w_b2[4];
    assign w_disp = {w_b2[3:0], w_b3};

    always_comb begin
        if (w_left_raw == 3'd0) begin
            w_left = 3'd1;
        end else if (w_left_raw > 3'd4) begin
            w_left = 3'd4;
        end else begin
            w_left = w_left_raw;
        end
    end

    always_comb begin
        w_byte           = '0;
        w_byte.kind      = KIND_BYTE;
        w_byte.size      = 3'd1;
        w_byte.target    = {12'd0, w_b1};
        w_byte.printable = is_printable(w_b1);
        w_word           = '0;
        w_word.kind      = KIND_WORD;
        w_word.size      = 3'd3;
        w_word.target    = {w_b1[3:0], w_b2, w_b3};
    end

    always_comb begin
        if (w_e) begin
            w_tgt = {w_b2[3:0], w_b3, w_b4};
        end else if (w_p) begin
            w_tgt = w_loc + 20'd3 + {{8{w_disp[11]}}, w_disp};
        end else if (w_b && r_base_valid) begin
            w_tgt = r_base + {8'd0, w_disp};
        end else begin
            w_tgt = {8'd0, w_disp};
        end
    end

    always_comb begin
        w_dec = '0;
        if (w_b1[1:0] == 2'b00 && w_fmt == FMT_1) begin
            w_dec.kind   = KIND_FMT1;
            w_dec.size   = 3'd1;
            w_dec.opcode = w_b1;
        end else if (w_fmt == FMT_NONE) begin
            if (is_printable(w_b1) && w_left >= 3'd2 && is_printable(w_b2)) begin
                w_dec = w_byte;
            end else if (w_left >= 3'd3) begin
                w_dec = w_word;
            end else begin
                w_dec = w_byte;
            end
        end else if (w_fmt == FMT_1) begin
            w_dec = w_byte;
        end else if (w_fmt == FMT_2) begin
            if (w_left < 3'd2) begin
                w_dec = w_byte;
            end else begin
                w_dec.kind    = KIND_FMT2;
                w_dec.size    = 3'd2;
                w_dec.opcode  = w_op;
                w_dec.reg_one = w_b2[7:4];
                w_dec.reg_two = (w_op == OP_CLEAR || w_op == OP_TIXR) ? 4'd0 : w_b2[3:0];
            end
        end else if (w_left < 3'd3) begin
            w_dec = w_byte;
        end else if (w_x && (w_n != w_i)) begin
            w_dec = w_byte;
        end else if (!w_n && !w_i && !w_x && !w_b && !w_p && w_op != OP_RSUB) begin
            w_dec = w_word;
        end else if (w_e && w_left < 3'd4) begin
            w_dec = w_byte;
        end else begin
            w_dec.kind        = w_e ? KIND_FMT4 : KIND_FMT3;
            w_dec.size        = w_e ? 3'd4 : 3'd3;
            w_dec.relocatable = w_e && r_in_mod;
            w_dec.opcode      = w_op;
            if (!w_n && w_i) begin
                w_dec.addr_mode = AM_IMMEDIATE;
            end else if (w_n && !w_i) begin
                w_dec.addr_mode = AM_INDIRECT;
            end else begin
                w_dec.addr_mode = AM_SIMPLE;
            end
            w_dec.indexed   = w_x;
            w_dec.target    = w_tgt & TGT_MASK;
            w_dec.sets_base = (w_op == OP_LDB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_base       <= '0;
            r_base_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_load_base) begin
                r_base       <= w_dec.target;
                r_base_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata[54:0];
            r_in_mod  <= i_s_tuser[0];
        end
        if (w_adv && r_in_valid) begin
            r_out <= w_dec;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {3'd0, r_out.sets_base, r_out.printable, r_out.relocatable,
                         r_out.target, r_out.reg_two, r_out.reg_one, r_out.indexed,
                         r_out.addr_mode, r_out.opcode, r_out.size};

    a_base_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_valid |=> r_base_valid)
        else $error("base valid flag dropped without reset");

    a_base_changes_on_ldb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_base != $past(r_base)) |-> $past(w_load_base))
        else $error("base register changed without an LDB transfer");

    a_sets_base_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sets_base) |->
            (r_out.kind == KIND_FMT3 || r_out.kind == KIND_FMT4))
        else $error("sets_base on an item that is not format 3 or 4");

    a_printable_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.printable) |->
            (r_out.kind == KIND_BYTE && r_out.size == 3'd1))
        else $error("printable flag on an item that is not a data byte");

    a_reloc_fmt4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.relocatable) |->
            (r_out.kind == KIND_FMT4 && r_out.size == 3'd4))
        else $error("relocatable flag on an item that is not format 4");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for sicxe_instruction_decoder_core: streams object-code windows
// through the decoder and checks every decoded item against an in-bench decode model.
// Depends on sxid_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench
    import sxid_pkg::*;
();

    typedef struct packed {
        logic        mod;
        logic [2:0]  left;
        logic [7:0]  b4;
        logic [7:0]  b3;
        logic [7:0]  b2;
        logic [7:0]  b1;
        logic [19:0] loc;
    } t_window;

    // Opcode classes, one bit per opcode with its n and i bits dropped.
    localparam logic [63:0] FMT34_MAP = 64'h01C0_0004_2E7D_FEFF;
    localparam logic [63:0] FMT2_MAP  = 64'h0000_6100_0000_0000;
    localparam logic [63:0] FMT1_MAP  = 64'h7003_0000_0000_0000;
    localparam logic [63:0] KNOWN_MAP = FMT34_MAP | FMT2_MAP | FMT1_MAP;

    localparam logic [7:0] OP_LDA   = 8'h00;
    localparam logic [7:0] OP_JSUB  = 8'h48;
    localparam logic [7:0] OP_COMPR = 8'hA0;
    localparam logic [7:0] OP_FIX   = 8'hC4;
    localparam logic [7:0] OP_RD    = 8'hD8;

    localparam int N_RANDOM     = 1650;
    localparam int PHASE_LEN    = 560;
    localparam int HOLD_AT      = 1250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    t_window window_q[$];
    t_dec    decoded_q[$];
    logic    in_fire = 1'b0;
    int      n_accepted = 0;
    int      n_results = 0;
    int      n_mismatch = 0;
    int      n_cycles = 0;
    int      n_base_loads = 0;
    int      kind_count[6];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left = 0;
    logic    hold_done = 1'b0;
    logic [19:0] base_reg = '0;
    logic        base_known = 1'b0;

    sicxe_instruction_decoder_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic t_window window_of(input logic [19:0] loc, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [7:0] b4, input logic [2:0] left,
                                          input logic mod);
        t_window w;
        w = '{mod: mod, left: left, b4: b4, b3: b3, b2: b2, b1: b1, loc: loc};
        return w;
    endfunction

    task automatic queue_window(input t_window w);
        window_q.insert(window_q.size(), w);
    endtask

    function automatic logic in_text_range(input logic [7:0] v);
        return v >= 8'h20 && v <= 8'h7E;
    endfunction

    function automatic t_dec data_byte(input logic [7:0] v);
        t_dec r;
        r = '0;
        r.kind = KIND_BYTE;
        r.size = 3'd1;
        r.target = {12'd0, v};
        r.printable = in_text_range(v);
        return r;
    endfunction

    function automatic t_dec data_word(input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [7:0] b3);
        t_dec r;
        r = '0;
        r.kind = KIND_WORD;
        r.size = 3'd3;
        r.target = {b1[3:0], b2, b3};
        return r;
    endfunction

    function automatic t_dec decode_window(input t_window w);
        t_dec        r;
        logic [2:0]  left;
        logic [7:0]  op;
        logic [5:0]  idx;
        logic        n, i, x, b, p, e;
        logic [11:0] disp;
        logic [19:0] tgt;
        r = '0;
        left = w.left;
        if (left == 3'd0) begin
            left = 3'd1;
        end else if (left > 3'd4) begin
            left = 3'd4;
        end
        op = w.b1 & OPC_MASK;
        idx = op[7:2];
        n = w.b1[1];
        i = w.b1[0];
        x = w.b2[7];
        b = w.b2[6];
        p = w.b2[5];
        e = w.b2[4];
        disp = {w.b2[3:0], w.b3};
        if (FMT1_MAP[idx]) begin
            if (w.b1[1:0] == 2'b00) begin
                r.kind = KIND_FMT1;
                r.size = 3'd1;
                r.opcode = w.b1;
            end else begin
                r = data_byte(w.b1);
            end
        end else if (FMT2_MAP[idx]) begin
            if (left < 3'd2) begin
                r = data_byte(w.b1);
            end else begin
                r.kind = KIND_FMT2;
                r.size = 3'd2;
                r.opcode = op;
                r.reg_one = w.b2[7:4];
                r.reg_two = (op == OP_CLEAR || op == OP_TIXR) ? 4'd0 : w.b2[3:0];
            end
        end else if (!FMT34_MAP[idx]) begin
            if (in_text_range(w.b1) && left >= 3'd2 && in_text_range(w.b2)) begin
                r = data_byte(w.b1);
            end else if (left >= 3'd3) begin
                r = data_word(w.b1, w.b2, w.b3);
            end else begin
                r = data_byte(w.b1);
            end
        end else if (left < 3'd3 || (x && n != i)) begin
            r = data_byte(w.b1);
        end else if (!n && !i && !x && !b && !p && op != OP_RSUB) begin
            r = data_word(w.b1, w.b2, w.b3);
        end else if (e && left < 3'd4) begin
            r = data_byte(w.b1);
        end else begin
            if (e) begin
                tgt = {w.b2[3:0], w.b3, w.b4};
                r.kind = KIND_FMT4;
                r.size = 3'd4;
                r.relocatable = w.mod;
            end else begin
                if (p) begin
                    tgt = w.loc + 20'd3 + {{8{disp[11]}}, disp};
                end else if (b && base_known) begin
                    tgt = base_reg + {8'd0, disp};
                end else begin
                    tgt = {8'd0, disp};
                end
                r.kind = KIND_FMT3;
                r.size = 3'd3;
            end
            r.opcode = op;
            r.addr_mode = (!n && i) ? AM_IMMEDIATE : ((n && !i) ? AM_INDIRECT : AM_SIMPLE);
            r.indexed = x;
            r.target = tgt;
            if (op == OP_LDB) begin
                base_reg = tgt;
                base_known = 1'b1;
                r.sets_base = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic string describe(input t_dec d);
        return {$sformatf("kind=%0d size=%0d op=%02h mode=%0d x=%0b r1=%0h r2=%0h ",
                          d.kind, d.size, d.opcode, d.addr_mode, d.indexed, d.reg_one,
                          d.reg_two),
                $sformatf("tgt=%05h rel=%0b prt=%0b ldb=%0b",
                          d.target, d.relocatable, d.printable, d.sets_base)};
    endfunction

    always_comb begin
        if (n_accepted < PHASE_LEN) begin
            send_idle_pct = 25;
            recv_idle_pct = 54;
        end else if (n_accepted < 2 * PHASE_LEN) begin
            send_idle_pct = 54;
            recv_idle_pct = 25;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    always @(negedge clk) begin : drive_windows
        t_window w;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (window_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                w = window_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, w[54:0]};
                s_tuser <= w.mod;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_dec got;
        t_dec want;
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready) begin
            decoded_q.insert(decoded_q.size(),
                             decode_window(t_window'({s_tuser, s_tdata[54:0]})));
            n_accepted++;
        end
        if (rst_n && m_tvalid && m_tready) begin
            got.kind = t_kind'(m_tuser);
            got.size = m_tdata[2:0];
            got.opcode = m_tdata[10:3];
            got.addr_mode = t_amode'(m_tdata[12:11]);
            got.indexed = m_tdata[13];
            got.reg_one = m_tdata[17:14];
            got.reg_two = m_tdata[21:18];
            got.target = m_tdata[41:22];
            got.relocatable = m_tdata[42];
            got.printable = m_tdata[43];
            got.sets_base = m_tdata[44];
            n_results++;
            if (decoded_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("Unexpected result %0d: %s", n_results, describe(got));
                end
            end else begin
                want = decoded_q.pop_front();
                if (want.kind <= KIND_BYTE) begin
                    kind_count[want.kind]++;
                end
                if (want.sets_base) begin
                    n_base_loads++;
                end
                if (got.kind !== want.kind || got.size !== want.size
                        || got.opcode !== want.opcode || got.addr_mode !== want.addr_mode
                        || got.indexed !== want.indexed || got.reg_one !== want.reg_one
                        || got.reg_two !== want.reg_two || got.target !== want.target
                        || got.relocatable !== want.relocatable
                        || got.printable !== want.printable
                        || got.sets_base !== want.sets_base) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("Mismatch at result %0d: expected %s", n_results, describe(want));
                        $display("                      actual   %s", describe(got));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     n_cycles, decoded_q.size());
            $display("sicxe_instruction_decoder_core test failed");
            $finish;
        end
    end

    initial begin : run_test
        t_window    w;
        int         pick;
        int         n_windows;
        logic [5:0] opi;
        queue_window(window_of(20'h00000, OP_LDA | 8'h03, 8'h4F, 8'hFF, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'hFFFFF, OP_FIX, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0));
        queue_window(window_of(20'h00010, OP_FIX | 8'h01, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b1));
        queue_window(window_of(20'h00011, OP_FIX, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0));
        queue_window(window_of(20'h00012, OP_CLEAR, 8'h3A, 8'h00, 8'h00, 3'd2, 1'b0));
        queue_window(window_of(20'h00014, OP_TIXR, 8'h51, 8'h77, 8'h88, 3'd4, 1'b0));
        queue_window(window_of(20'h00016, OP_COMPR, 8'hF0, 8'h00, 8'h00, 3'd2, 1'b0));
        queue_window(window_of(20'h00018, OP_COMPR, 8'h0F, 8'h00, 8'h00, 3'd1, 1'b0));
        queue_window(window_of(20'h00019, 8'h21, 8'h41, 8'h42, 8'h43, 3'd4, 1'b0));
        queue_window(window_of(20'h0001A, 8'h20, 8'h00, 8'hAB, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'h0001D, 8'hFC, 8'hFF, 8'hFF, 8'hFF, 3'd2, 1'b1));
        queue_window(window_of(20'h0001E, 8'h7E, 8'h7E, 8'h00, 8'h00, 3'd1, 1'b0));
        queue_window(window_of(20'h00020, OP_LDA | 8'h03, 8'h30, 8'h00, 8'h00, 3'd2, 1'b0));
        queue_window(window_of(20'h00021, OP_LDA | 8'h01, 8'h80, 8'h12, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'h00022, OP_LDA, 8'h10, 8'h55, 8'h66, 3'd4, 1'b0));
        queue_window(window_of(20'h00025, OP_RSUB, 8'h00, 8'h00, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'hFFFFF, OP_LDB | 8'h03, 8'h2F, 8'hF0, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'h00002, OP_LDA | 8'h03, 8'h4F, 8'hFF, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'h00100, OP_LDA | 8'h03, 8'h68, 8'h00, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'h00103, OP_JSUB | 8'h03, 8'h1F, 8'hFF, 8'hFF, 3'd4, 1'b1));
        queue_window(window_of(20'h00107, OP_JSUB | 8'h03, 8'h10, 8'h00, 8'h00, 3'd3, 1'b1));
        queue_window(window_of(20'h00108, OP_JSUB | 8'h03, 8'h10, 8'h12, 8'h34, 3'd7, 1'b1));
        queue_window(window_of(20'h0010C, OP_LDA | 8'h01, 8'h00, 8'h2A, 8'h00, 3'd5, 1'b0));
        queue_window(window_of(20'h0010F, OP_LDA | 8'h02, 8'h20, 8'h04, 8'h00, 3'd3, 1'b0));
        queue_window(window_of(20'h00112, OP_RD | 8'h03, 8'hC0, 8'h10, 8'h00, 3'd4, 1'b0));
        queue_window(window_of(20'h00115, OP_LDB | 8'h01, 8'h1F, 8'hAB, 8'hCD, 3'd4, 1'b0));
        queue_window(window_of(20'h00119, OP_LDA | 8'h03, 8'h40, 8'h01, 8'h00, 3'd3, 1'b0));
        repeat (N_RANDOM) begin
            w.loc = 20'($urandom);
            if ($urandom_range(9) == 0) begin
                w.loc = 20'hFFFFF - 20'($urandom_range(15));
            end
            pick = $urandom_range(99);
            if (pick < 80) begin
                do begin
                    opi = 6'($urandom_range(63));
                end while (!KNOWN_MAP[opi]);
                if (pick < 6) begin
                    opi = OP_LDB[7:2];
                end
                w.b1 = {opi, 2'($urandom)};
                if (FMT1_MAP[opi] && $urandom_range(3) != 0) begin
                    w.b1[1:0] = 2'b00;
                end else if (FMT34_MAP[opi] && w.b1[1:0] == 2'b00 && $urandom_range(3) != 0) begin
                    w.b1[1:0] = 2'b11;
                end
            end else begin
                w.b1 = 8'($urandom);
            end
            w.b2 = 8'($urandom);
            w.b3 = 8'($urandom);
            w.b4 = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 60) begin
                w.left = 3'd4;
            end else if (pick < 95) begin
                w.left = 3'($urandom_range(1, 4));
            end else begin
                w.left = 3'($urandom_range(0, 7));
            end
            w.mod = 1'($urandom);
            queue_window(w);
        end
        n_windows = window_q.size();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        while (n_accepted < n_windows || decoded_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d decoded items from %0d windows with %0d mismatches.",
                 n_results, n_accepted, n_mismatch);
        $display("Kinds fmt1/fmt2/fmt3/fmt4/word/byte: %0d/%0d/%0d/%0d/%0d/%0d, base loads: %0d.",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 kind_count[4], kind_count[5], n_base_loads);
        if (n_mismatch == 0) begin
            $display("sicxe_instruction_decoder_core test passed");
        end else begin
            $display("sicxe_instruction_decoder_core test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/sxid_pkg.sv
design/sicxe_instruction_decoder_core.sv
dv/testbench.sv
